// File: rtl/ssi_pkg.sv
`timescale 1ns / 1ps
// Shared types for the segment and sphere crossing block.
// Holds the result status codes and the register indexes; no dependencies.
package ssi_pkg;

	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_FLUID_IN = 3'd1,
		STAT_WALL_OUT = 3'd2,
		STAT_ZERO_SEG = 3'd3,
		STAT_NEG_DISC = 3'd4,
		STAT_RANGE    = 3'd5
	} status_t;

	localparam int CFG_ADDR_W = 2;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_CENTER_X  = 2'd0,
		REG_CENTER_Y  = 2'd1,
		REG_CENTER_Z  = 2'd2,
		REG_RADIUS_SQ = 2'd3
	} reg_idx_t;

endpackage

// File: rtl/segment_sphere_intersection_top.sv
`timescale 1ns / 1ps
// Pipelined crossing point of a segment with a configured sphere.
// Depends on ssi_pkg for status codes and register indexes.
//
//  channel  | dir | handshake        | contents
//  ---------+-----+------------------+----------------------------------------
//  config   | in  | cfg_we           | cfg_addr, cfg_data
//  s_*      | in  | s_tvalid/tready  | fluid x,y,z then wall x,y,z
//  m_*      | out | m_tvalid/tready  | alpha in m_tdata, status in m_tuser
//
// One word enters per cycle unless the output stalls. The pipeline holds a
// one-bit-per-stage square root and a one-bit-per-stage divider. Reset clears
// all valid bits and the configuration registers.
// A stall at the output freezes the whole pipeline; s_tready is low only
// while a result waits in the output register and m_tready is low.
module segment_sphere_intersection_top
	import ssi_pkg::*;
#(
	parameter int COORD_WIDTH = 24,
	parameter int ALPHA_FRAC = 16,
	localparam int IN_W = ((6 * COORD_WIDTH + 7) / 8) * 8,
	localparam int ALPHA_W = ALPHA_FRAC + 1,
	localparam int OUT_W = ((ALPHA_W + 7) / 8) * 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [2*COORD_WIDTH-1:0]  cfg_data,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// fluid_x, fluid_y, fluid_z, wall_x, wall_y, wall_z
	input  logic [IN_W-1:0]           s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// alpha
	output logic [OUT_W-1:0]          m_tdata,
	// status
	output logic [2:0]                m_tuser
);

	localparam int W = COORD_WIDTH;
	localparam int F = ALPHA_FRAC;
	localparam int DW = W + 1;
	localparam int PW = 2 * DW;
	localparam int A_W = 2 * W + 2;
	localparam int H_W = 2 * W + 3;
	localparam int HB = (A_W + 1) / 2;
	localparam int HI_W = A_W - HB;
	localparam int P_W = 2 * A_W;
	localparam int R_W = A_W + F;
	localparam int RAD_W = P_W + 2 * F;
	localparam int REM_W = R_W + 2;
	localparam int LIM_W = R_W + 1;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << F;

	logic signed [W-1:0]   cx_q, cy_q, cz_q;
	logic [2*W-1:0]        r2_q;
	logic                  en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
			cz_q <= '0;
			r2_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_CENTER_X:  cx_q <= cfg_data[W-1:0];
				REG_CENTER_Y:  cy_q <= cfg_data[W-1:0];
				REG_CENTER_Z:  cz_q <= cfg_data[W-1:0];
				REG_RADIUS_SQ: r2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: offsets from the centre and the segment direction.
	logic signed [W-1:0]  pf [3];
	logic signed [W-1:0]  pw [3];
	logic signed [W-1:0]  cen [3];
	logic signed [DW-1:0] f_d [3];
	logic signed [DW-1:0] g_d [3];
	logic signed [DW-1:0] d_d [3];
	logic signed [DW-1:0] f_s1 [3];
	logic signed [DW-1:0] g_s1 [3];
	logic signed [DW-1:0] d_s1 [3];
	logic                 vld_s1;

	always_comb begin
		cen[0] = cx_q;
		cen[1] = cy_q;
		cen[2] = cz_q;
		for (int i = 0; i < 3; i++) begin
			pf[i] = s_tdata[i*W +: W];
			pw[i] = s_tdata[(i+3)*W +: W];
			f_d[i] = DW'(pf[i]) - DW'(cen[i]);
			g_d[i] = DW'(pw[i]) - DW'(cen[i]);
			d_d[i] = DW'(pw[i]) - DW'(pf[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s1 <= f_d;
			g_s1 <= g_d;
			d_s1 <= d_d;
		end
	end

	// Stage 2: squares and direction-offset products.
	logic signed [PW-1:0] fp_s2 [3];
	logic signed [PW-1:0] gp_s2 [3];
	logic signed [PW-1:0] dp_s2 [3];
	logic signed [PW-1:0] hp_s2 [3];
	logic                 vld_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				fp_s2[i] <= f_s1[i] * f_s1[i];
				gp_s2[i] <= g_s1[i] * g_s1[i];
				dp_s2[i] <= d_s1[i] * d_s1[i];
				hp_s2[i] <= d_s1[i] * f_s1[i];
			end
		end
	end

	// Stage 3: sums.
	logic [A_W-1:0]        fsq_s3, gsq_s3, a_s3;
	logic signed [H_W-1:0] h_s3;
	logic                  vld_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			fsq_s3 <= A_W'($unsigned(fp_s2[0])) + A_W'($unsigned(fp_s2[1]))
				+ A_W'($unsigned(fp_s2[2]));
			gsq_s3 <= A_W'($unsigned(gp_s2[0])) + A_W'($unsigned(gp_s2[1]))
				+ A_W'($unsigned(gp_s2[2]));
			a_s3 <= A_W'($unsigned(dp_s2[0])) + A_W'($unsigned(dp_s2[1]))
				+ A_W'($unsigned(dp_s2[2]));
			h_s3 <= H_W'(hp_s2[0]) + H_W'(hp_s2[1]) + H_W'(hp_s2[2]);
		end
	end

	// Stage 4: containment tests, c term and magnitude of h.
	logic signed [H_W-1:0] h_abs;
	logic [A_W-1:0]        hm_s4, a_s4, cc_s4;
	logic                  fin_s4, wout_s4, az_s4, hneg_s4, vld_s4;

	assign h_abs = h_s3[H_W-1] ? -h_s3 : h_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			fin_s4 <= fsq_s3 <= A_W'(r2_q);
			wout_s4 <= gsq_s3 > A_W'(r2_q);
			az_s4 <= a_s3 == '0;
			cc_s4 <= fsq_s3 - A_W'(r2_q);
			hneg_s4 <= h_s3[H_W-1];
			hm_s4 <= A_W'($unsigned(h_abs));
			a_s4 <= a_s3;
		end
	end

	// Stage 5: partial products of h*h and a*c.
	logic [2*HB-1:0]    hll_s5, acll_s5;
	logic [A_W-1:0]     hlh_s5, aclh_s5, achl_s5;
	logic [2*HI_W-1:0]  hhh_s5, achh_s5;
	logic [A_W-1:0]     hm_s5, a_s5;
	logic               fin_s5, wout_s5, az_s5, hneg_s5, vld_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			hll_s5 <= hm_s4[HB-1:0] * hm_s4[HB-1:0];
			hlh_s5 <= hm_s4[HB-1:0] * hm_s4[A_W-1:HB];
			hhh_s5 <= hm_s4[A_W-1:HB] * hm_s4[A_W-1:HB];
			acll_s5 <= a_s4[HB-1:0] * cc_s4[HB-1:0];
			aclh_s5 <= a_s4[HB-1:0] * cc_s4[A_W-1:HB];
			achl_s5 <= a_s4[A_W-1:HB] * cc_s4[HB-1:0];
			achh_s5 <= a_s4[A_W-1:HB] * cc_s4[A_W-1:HB];
			hm_s5 <= hm_s4;
			a_s5 <= a_s4;
			fin_s5 <= fin_s4;
			wout_s5 <= wout_s4;
			az_s5 <= az_s4;
			hneg_s5 <= hneg_s4;
		end
	end

	// Stage 6: full products.
	logic [P_W-1:0] h2_s6, ac_s6;
	logic [A_W-1:0] hm_s6, a_s6;
	logic           fin_s6, wout_s6, az_s6, hneg_s6, vld_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			h2_s6 <= (P_W'(hhh_s5) << (2 * HB)) + (P_W'(hlh_s5) << (HB + 1))
				+ P_W'(hll_s5);
			ac_s6 <= (P_W'(achh_s5) << (2 * HB))
				+ ((P_W'(aclh_s5) + P_W'(achl_s5)) << HB) + P_W'(acll_s5);
			hm_s6 <= hm_s5;
			a_s6 <= a_s5;
			fin_s6 <= fin_s5;
			wout_s6 <= wout_s5;
			az_s6 <= az_s5;
			hneg_s6 <= hneg_s5;
		end
	end

	// Square root pipeline, one root bit per stage. Entry 0 is stage 7.
	logic [RAD_W-1:0] sq_rad_s  [R_W+1];
	logic [REM_W-1:0] sq_rem_s  [R_W+1];
	logic [R_W-1:0]   sq_root_s [R_W+1];
	logic [A_W-1:0]   sq_hm_s   [R_W+1];
	logic [A_W-1:0]   sq_a_s    [R_W+1];
	logic             sq_hneg_s [R_W+1];
	status_t          sq_stat_s [R_W+1];
	logic             sq_done_s [R_W+1];
	logic             sq_vld_s  [R_W+1];

	logic             neg_disc;
	logic [P_W-1:0]   disc;
	status_t          stat7;
	logic             done7;

	always_comb begin
		neg_disc = h2_s6 < ac_s6;
		disc = h2_s6 - ac_s6;
		done7 = 1'b1;
		if (fin_s6) begin
			stat7 = STAT_FLUID_IN;
		end else if (wout_s6) begin
			stat7 = STAT_WALL_OUT;
		end else if (az_s6) begin
			stat7 = STAT_ZERO_SEG;
		end else if (neg_disc) begin
			stat7 = STAT_NEG_DISC;
		end else begin
			stat7 = STAT_OK;
			done7 = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_rad_s[0] <= {disc, {(2*F){1'b0}}};
			sq_rem_s[0] <= '0;
			sq_root_s[0] <= '0;
			sq_hm_s[0] <= hm_s6;
			sq_a_s[0] <= a_s6;
			sq_hneg_s[0] <= hneg_s6;
			sq_stat_s[0] <= stat7;
			sq_done_s[0] <= done7;
		end
	end

	for (genvar k = 0; k < R_W; k++) begin : g_sqrt
		logic [REM_W-1:0] t;
		logic [REM_W-1:0] trial;
		logic             geq;

		assign t = {sq_rem_s[k][REM_W-3:0], sq_rad_s[k][RAD_W-1 -: 2]};
		assign trial = {sq_root_s[k], 2'b01};
		assign geq = t >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				sq_rad_s[k+1] <= sq_rad_s[k] << 2;
				sq_rem_s[k+1] <= geq ? t - trial : t;
				sq_root_s[k+1] <= {sq_root_s[k][R_W-2:0], geq};
				sq_hm_s[k+1] <= sq_hm_s[k];
				sq_a_s[k+1] <= sq_a_s[k];
				sq_hneg_s[k+1] <= sq_hneg_s[k];
				sq_stat_s[k+1] <= sq_stat_s[k];
				sq_done_s[k+1] <= sq_done_s[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_s[k+1] <= 1'b0;
			end else if (en) begin
				sq_vld_s[k+1] <= sq_vld_s[k];
			end
		end
	end

	// Stage R_W + 8: root sign checks and numerator.
	logic [R_W-1:0]   mh, root;
	status_t          stat8;
	logic             done8;
	logic [R_W-1:0]   num_s8;
	logic [LIM_W-1:0] lim_s8;
	logic [A_W-1:0]   a_s8;
	status_t          stat_s8;
	logic             done_s8, vld_s8;

	always_comb begin
		root = sq_root_s[R_W];
		mh = {sq_hm_s[R_W], {F{1'b0}}};
		stat8 = sq_stat_s[R_W];
		done8 = sq_done_s[R_W];
		if (!sq_done_s[R_W]) begin
			if (!sq_hneg_s[R_W]) begin
				done8 = 1'b1;
				stat8 = (sq_hm_s[R_W] == '0 && root == '0) ? STAT_OK : STAT_RANGE;
			end else if (mh < root) begin
				done8 = 1'b1;
				stat8 = STAT_RANGE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s8 <= mh - root;
			lim_s8 <= (LIM_W'(sq_a_s[R_W]) << F) + LIM_W'(sq_a_s[R_W]);
			a_s8 <= sq_a_s[R_W];
			stat_s8 <= stat8;
			done_s8 <= done8;
		end
	end

	// Divider pipeline, one quotient bit per stage. Entry 0 is stage R_W + 9.
	logic [R_W-1:0]     dv_rem_s   [F+2];
	logic [ALPHA_W-1:0] dv_q_s     [F+2];
	logic [A_W-1:0]     dv_a_s     [F+2];
	logic [ALPHA_W-1:0] dv_alpha_s [F+2];
	status_t            dv_stat_s  [F+2];
	logic               dv_done_s  [F+2];
	logic               dv_vld_s   [F+2];
	logic               sat;

	assign sat = !done_s8 && ({1'b0, num_s8} >= lim_s8);

	always_ff @(posedge clk) begin
		if (en) begin
			dv_rem_s[0] <= num_s8;
			dv_q_s[0] <= '0;
			dv_a_s[0] <= a_s8;
			dv_alpha_s[0] <= sat ? ALPHA_ONE : '0;
			dv_stat_s[0] <= sat ? STAT_RANGE : stat_s8;
			dv_done_s[0] <= done_s8 || sat;
		end
	end

	for (genvar j = 0; j <= F; j++) begin : g_div
		localparam int K = F - j;
		logic [R_W-1:0]     dvs;
		logic               geq;
		logic [ALPHA_W-1:0] q_next;

		assign dvs = R_W'(dv_a_s[j]) << K;
		assign geq = dv_rem_s[j] >= dvs;

		always_comb begin
			q_next = dv_q_s[j];
			q_next[K] = geq;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_rem_s[j+1] <= geq ? dv_rem_s[j] - dvs : dv_rem_s[j];
				dv_q_s[j+1] <= q_next;
				dv_a_s[j+1] <= dv_a_s[j];
				dv_alpha_s[j+1] <= dv_alpha_s[j];
				dv_stat_s[j+1] <= dv_stat_s[j];
				dv_done_s[j+1] <= dv_done_s[j];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[j+1] <= 1'b0;
			end else if (en) begin
				dv_vld_s[j+1] <= dv_vld_s[j];
			end
		end
	end

	// Output register.
	logic [ALPHA_W-1:0] out_alpha_q;
	status_t            out_stat_q;
	logic               out_vld_q;

	always_ff @(posedge clk) begin
		if (en) begin
			out_alpha_q <= dv_done_s[F+1] ? dv_alpha_s[F+1] : dv_q_s[F+1];
			out_stat_q <= dv_stat_s[F+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			sq_vld_s[0] <= 1'b0;
			vld_s8 <= 1'b0;
			dv_vld_s[0] <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			sq_vld_s[0] <= vld_s6;
			vld_s8 <= sq_vld_s[R_W];
			dv_vld_s[0] <= vld_s8;
			out_vld_q <= dv_vld_s[F+1];
		end
	end

	assign en = !out_vld_q || m_tready;
	assign s_tready = en;
	assign m_tvalid = out_vld_q;
	assign m_tdata = OUT_W'(out_alpha_q);
	assign m_tuser = out_stat_q;

`ifndef SYNTHESIS
	a_ok_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == STAT_OK) |-> (m_tdata[ALPHA_W-1:0] <= ALPHA_ONE))
		else $error("alpha above one with an ok status");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == STAT_FLUID_IN || m_tuser == STAT_WALL_OUT
		|| m_tuser == STAT_ZERO_SEG || m_tuser == STAT_NEG_DISC)
		|-> (m_tdata[ALPHA_W-1:0] == '0))
		else $error("nonzero alpha on a rejected segment");

	a_range_val: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == STAT_RANGE)
		|-> (m_tdata[ALPHA_W-1:0] == '0 || m_tdata[ALPHA_W-1:0] == ALPHA_ONE))
		else $error("out of range alpha is neither zero nor saturated");

	a_sqrt_rem: assert property (@(posedge clk) disable iff (!arst_n)
		sq_vld_s[R_W] && !sq_done_s[R_W]
		|-> (sq_rem_s[R_W] <= {1'b0, sq_root_s[R_W], 1'b0}))
		else $error("square root remainder exceeds twice the root");
`endif

endmodule

// File: verif/segment_sphere_intersection_top_test.sv
`timescale 1ns / 1ps
// Self-checking bench for segment_sphere_intersection_top: a scoreboard class predicts
// alpha and status per input word, tasks drive config and stream traffic, and an always block drives stalls.
// Depends on ssi_pkg and the top-level RTL only.
module segment_sphere_intersection_top_test;
	import ssi_pkg::*;

	typedef struct {
		logic [16:0] alpha;
		status_t     status;
	} crossing_t;

	class crossing_scoreboard;
		logic [23:0] center[3];
		logic [47:0] radius_sq;
		crossing_t   pending_q[$];
		int          mismatches;

		function bit [255:0] isqrt(bit [255:0] x);
			bit [255:0] r;
			bit [255:0] cand;
			r = 0;
			for (int i = 127; i >= 0; i--) begin
				cand = r | (256'd1 << i);
				if (cand * cand <= x) r = cand;
			end
			return r;
		endfunction

		function void note_input(logic [143:0] w);
			longint f, g, d, fsq, gsq, a, h, hm, r2;
			bit [255:0] h2, ac, s, mh, q;
			crossing_t e;
			fsq = 0; gsq = 0; a = 0; h = 0;
			for (int i = 0; i < 3; i++) begin
				f = longint'($signed(w[24*i +: 24])) - longint'($signed(center[i]));
				g = longint'($signed(w[24*(i+3) +: 24])) - longint'($signed(center[i]));
				d = g - f;
				fsq += f * f; gsq += g * g; a += d * d; h += d * f;
			end
			r2 = longint'({16'd0, radius_sq});
			e.alpha = 0;
			e.status = STAT_OK;
			if (fsq <= r2) e.status = STAT_FLUID_IN;
			else if (gsq > r2) e.status = STAT_WALL_OUT;
			else if (a == 0) e.status = STAT_ZERO_SEG;
			else begin
				hm = (h < 0) ? -h : h;
				h2 = 256'(hm) * 256'(hm);
				ac = 256'(a) * 256'(fsq - r2);
				if (h2 < ac) e.status = STAT_NEG_DISC;
				else begin
					s = isqrt((h2 - ac) << 32);
					mh = 256'(hm) << 16;
					if (h >= 0) begin
						if (!(hm == 0 && s == 0)) e.status = STAT_RANGE;
					end else if (mh < s) e.status = STAT_RANGE;
					else begin
						q = (mh - s) / 256'(a);
						if (q > 65536) begin
							e.status = STAT_RANGE;
							e.alpha = 17'd65536;
						end else e.alpha = q[16:0];
					end
				end
			end
			pending_q.push_back(e);
		endfunction

		function void check_result(logic [23:0] data, logic [2:0] user);
			crossing_t e;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected word: alpha %0d status %0d", data, user);
				return;
			end
			e = pending_q.pop_front();
			if (data !== {7'd0, e.alpha} || user !== e.status) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Mismatch: expected alpha %0d status %0d, got alpha %0d status %0d",
						e.alpha, e.status, data, user);
			end
		endfunction
	endclass

	logic clk, arst_n, cfg_we, s_tvalid, s_tready, m_tvalid, m_tready;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [47:0] cfg_data;
	logic [143:0] s_tdata;
	logic [23:0] m_tdata;
	logic [2:0] m_tuser;

	crossing_scoreboard sb = new();
	bit idle_on = 1;
	int stall_left = 0;
	int quiet_cycles = 0;
	int radius_int;
	int cx[3];

	segment_sphere_intersection_top dut (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (s_tvalid && s_tready) sb.note_input(s_tdata);
		if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= 20000) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 3);
			m_tready <= 0;
		end else m_tready <= 1;
	end

	task write_reg(reg_idx_t idx, logic [47:0] value);
		cfg_we <= 1;
		cfg_addr <= idx;
		cfg_data <= value;
		@(negedge clk);
		if (idx == REG_RADIUS_SQ) sb.radius_sq = value;
		else sb.center[idx] = value[23:0];
	endtask

	task set_sphere(int x, int y, int z, logic [47:0] rsq);
		cx[0] = x; cx[1] = y; cx[2] = z;
		write_reg(REG_CENTER_X, 48'(x[23:0]));
		write_reg(REG_CENTER_Y, 48'(y[23:0]));
		write_reg(REG_CENTER_Z, 48'(z[23:0]));
		write_reg(REG_RADIUS_SQ, rsq);
		cfg_we <= 0;
	endtask

	task send_word(logic [143:0] w);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= w;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task send_points(int f[3], int g[3]);
		send_word({g[2][23:0], g[1][23:0], g[0][23:0], f[2][23:0], f[1][23:0], f[0][23:0]});
	endtask

	task send_random;
		int f[3], g[3];
		int ax;
		if ($urandom_range(0, 9) < 3) begin
			send_word(144'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()}));
			return;
		end
		ax = $urandom_range(0, 2);
		for (int i = 0; i < 3; i++) begin
			g[i] = cx[i] + $urandom_range(0, radius_int) - radius_int / 2;
			f[i] = cx[i] + $urandom_range(0, 2 * radius_int) - radius_int;
		end
		f[ax] = cx[ax] + ($urandom_range(0, 1) ? 1 : -1) *
			(radius_int + 1 + $urandom_range(0, radius_int));
		send_points(f, g);
	endtask

	task drain;
		s_tvalid <= 0;
		while (sb.pending_q.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	initial begin
		int f[3], g[3];
		arst_n = 0;
		cfg_we = 0;
		cfg_addr = REG_CENTER_X;
		cfg_data = 0;
		s_tvalid = 0;
		s_tdata = 0;
		m_tready = 0;
		sb.center = '{default: 0};
		sb.radius_sq = 0;
		cx = '{default: 0};
		radius_int = 4096;
		repeat (4) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Reset sphere is a single point: tangent and degenerate cases.
		f = '{4096, 0, 0}; g = '{0, 0, 0};
		send_points(f, g);
		send_points(g, g);
		send_points(g, f);
		send_points(f, f);
		f = '{8388607, 8388607, 8388607}; g = '{-8388608, -8388608, -8388608};
		send_points(f, g);
		send_points(g, f);
		drain();

		set_sphere(0, 0, 0, 48'd1677721600);
		radius_int = 40960;
		f = '{81920, 0, 0}; g = '{0, 0, 0};
		send_points(f, g);
		send_points(g, f);
		g = '{40960, 0, 0};
		send_points(f, g);
		g = '{81920, 0, 0};
		send_points(f, g);
		f = '{81920, 81920, 0}; g = '{0, 81920, 0};
		send_points(f, g);
		f = '{-81920, 0, 0}; g = '{81920, 0, 0};
		send_points(f, g);
		f = '{0, -8388608, 8388607}; g = '{-20000, 10000, 0};
		send_points(f, g);
		for (int n = 0; n < 80; n++) send_random();
		drain();

		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: begin
					radius_int = 1 << 20;
					set_sphere(8388607, 8388607, 8388607, 48'hFFFF_FFFF_FFFF);
				end
				1: begin
					radius_int = 4096;
					set_sphere(-8388608, -8388608, -8388608, 48'd0);
				end
				default: begin
					radius_int = $urandom_range(256, 1 << 20);
					set_sphere($urandom_range(0, 1 << 23) - (1 << 22),
						$urandom_range(0, 1 << 23) - (1 << 22),
						$urandom_range(0, 1 << 23) - (1 << 22),
						48'(longint'(radius_int) * radius_int + $urandom_range(0, 3)));
				end
			endcase
			if (ph == 6) idle_on = 0;
			for (int n = 0; n < 95; n++) begin
				if (ph == 3 && n == 40) begin
					s_tvalid <= 0;
					while (sb.pending_q.size() != 0) @(negedge clk);
				end
				send_random();
			end
			drain();
		end

		if (sb.mismatches == 0 && sb.pending_q.size() == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end
endmodule

// File: sim.f
rtl/ssi_pkg.sv
rtl/segment_sphere_intersection_top.sv
verif/segment_sphere_intersection_top_test.sv
